FILE: rtl/core/qlu_pkg.sv
// ============================================================================
// qlu_pkg
// Shared types, constants and helper functions of the Q-learning update unit
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qlu_pkg;

    localparam int NUM_STATES  = 256;
    localparam int NUM_ACTIONS = 4;
    localparam int VALUE_W     = 16;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int ACTION_W    = $clog2(NUM_ACTIONS);
    localparam int ROW_W       = NUM_ACTIONS * VALUE_W;

    localparam int RATE_W      = 9;
    localparam int THRESH_W    = 16;
    localparam int RATE_FRAC   = 8;
    localparam int RATE_ONE    = 1 << RATE_FRAC;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int GV_W        = VALUE_W + RATE_W + 1;
    localparam int D_W         = VALUE_W + RATE_W + 1;
    localparam int PROD_W      = D_W + RATE_W + 1;
    localparam int STEP_W      = PROD_W - 2 * RATE_FRAC;
    localparam int SUM_W       = STEP_W + 1;

    localparam logic [RATE_W-1:0]   LEARNING_RATE_RST     = RATE_W'(26);
    localparam logic [RATE_W-1:0]   DISCOUNT_RST          = RATE_W'(230);
    localparam logic [THRESH_W-1:0] EXPLORE_THRESHOLD_RST = THRESH_W'(6554);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEARNING_RATE     = 2'd0,
        CFG_DISCOUNT          = 2'd1,
        CFG_EXPLORE_THRESHOLD = 2'd2,
        CFG_LEARN_MODE        = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } command_t;

    typedef enum logic {
        MODE_QLEARN = 1'b0,
        MODE_SARSA  = 1'b1
    } learn_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SCALE,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef logic signed [VALUE_W-1:0]              value_t;
    typedef logic [NUM_ACTIONS-1:0][VALUE_W-1:0]    row_t;
    typedef logic [STATE_W-1:0]                     state_idx_t;
    typedef logic [ACTION_W-1:0]                    action_t;

    typedef struct packed {
        logic                  command;
        logic [7:0]            state_index;
        logic signed [15:0]    reward;
        logic [15:0]           explore_draw;
        logic [1:0]            random_action;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            chosen_action;
        logic                  explored;
        logic signed [15:0]    updated_value;
    } out_item_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

    typedef struct packed {
        logic load_gv;
        logic load_prod;
    } upd_ctrl_t;

    // lowest index among the maximal entries
    function automatic action_t greedy_action(input row_t row);
        action_t best;
        value_t  best_val;
        best     = '0;
        best_val = $signed(row[0]);
        for (int j = 1; j < NUM_ACTIONS; j++)
        begin
            if ($signed(row[j]) > best_val)
            begin
                best_val = $signed(row[j]);
                best     = ACTION_W'(j);
            end
        end
        return best;
    endfunction

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] rate);
        return (rate > RATE_W'(RATE_ONE)) ? RATE_W'(RATE_ONE) : rate;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qlu_qmem.sv
// ============================================================================
// qlu_qmem
// Q table storage: one row of all action values per state, two registered
// read ports, one full-row write port, row valid bits so unwritten rows read 0
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qlu_qmem (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire qlu_pkg::mem_ctrl_t  ctrl,
    input  wire qlu_pkg::state_idx_t addr_a,
    input  wire qlu_pkg::state_idx_t addr_b,
    input  wire qlu_pkg::state_idx_t wr_addr,
    input  wire qlu_pkg::row_t       wr_data,
    output qlu_pkg::row_t            rd_data_a,
    output qlu_pkg::row_t            rd_data_b
);
    import qlu_pkg::*;

    row_t                  mem [NUM_STATES];
    logic [NUM_STATES-1:0] row_valid_reg;
    row_t                  raw_a_reg;
    row_t                  raw_b_reg;
    logic                  hit_a_reg;
    logic                  hit_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            raw_a_reg <= mem[addr_a];
            raw_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            hit_a_reg     <= 1'b0;
            hit_b_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                hit_a_reg <= row_valid_reg[addr_a];
                hit_b_reg <= row_valid_reg[addr_b];
            end
        end
    end

    assign rd_data_a = hit_a_reg ? raw_a_reg : '0;
    assign rd_data_b = hit_b_reg ? raw_b_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/core/qlu_update.sv
// ============================================================================
// qlu_update
// Temporal-difference arithmetic: gamma*V, alpha*(r + gamma*V - q),
// rounding to the nearest Q8.8 step and saturation of the new value
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qlu_update (
    input  wire logic                      clk,
    input  wire qlu_pkg::upd_ctrl_t        ctrl,
    input  wire qlu_pkg::value_t           target_value,
    input  wire qlu_pkg::value_t           q_value,
    input  wire qlu_pkg::value_t           reward,
    input  wire logic [qlu_pkg::RATE_W-1:0] alpha,
    input  wire logic [qlu_pkg::RATE_W-1:0] gamma,
    output qlu_pkg::value_t                new_value
);
    import qlu_pkg::*;

    localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) <<< (2 * RATE_FRAC - 1);

    logic signed [GV_W-1:0]   gamma_ext;
    logic signed [GV_W-1:0]   target_ext;
    logic signed [GV_W-1:0]   gv_next;
    logic signed [GV_W-1:0]   gv_reg;
    value_t                   q_reg;
    logic signed [D_W-1:0]    delta;
    logic signed [PROD_W-1:0] alpha_ext;
    logic signed [PROD_W-1:0] delta_ext;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] biased;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;

    assign gamma_ext  = GV_W'(signed'({1'b0, gamma}));
    assign target_ext = GV_W'(target_value);
    assign gv_next    = gamma_ext * target_ext;

    assign delta = (D_W'(reward) <<< RATE_FRAC) + D_W'(gv_reg) - (D_W'(q_reg) <<< RATE_FRAC);

    assign alpha_ext = PROD_W'(signed'({1'b0, alpha}));
    assign delta_ext = PROD_W'(delta);
    assign prod_next = alpha_ext * delta_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_gv)
        begin
            gv_reg <= gv_next;
            q_reg  <= q_value;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // floor of (prod + half) / 2^16
    assign biased = prod_reg + ROUND_HALF;
    assign step   = biased[PROD_W-1:2*RATE_FRAC];
    assign sum    = SUM_W'(step) + SUM_W'(q_reg);

    always_comb
    begin
        if (sum > SUM_W'(VMAX))
        begin
            new_value = VMAX;
        end
        else if (sum < SUM_W'(VMIN))
        begin
            new_value = VMIN;
        end
        else
        begin
            new_value = sum[VALUE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tabular_q_learning_update_unit.sv
// ============================================================================
// tabular_q_learning_update_unit
// Epsilon-greedy Q-learning / SARSA engine over a Q table of Q8.8 values
// ============================================================================
// Input channel (in_valid / in_stall / in_data): a start transaction sets the
// current state and picks an action there; a step transaction moves to the
// next state with a reward and updates Q(s,a) of the current state and action.
// Output channel (out_valid / out_stall / out_data): one result transaction
// per input, carrying the chosen action, the explore flag and the new Q value
// (zero for a start).
// One transaction is worked at a time. A step goes accept, table read,
// evaluate, scale, write-back, result; a start skips scale and write-back.
// The result is registered when the engine leaves the result stage, and the
// next input is taken only once the engine is back in idle.
// The result register frees the engine: a new transaction is accepted while a
// result waits under out_stall; the engine holds its last stage only if a
// second result is ready before the first is taken.
// Reset clears the Q table at once (row valid bits), current state and action
// to zero, and the configuration registers to their defaults. Configuration
// writes on cfg_wr_en / cfg_index / cfg_data are to be made only when idle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tabular_q_learning_update_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [qlu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [qlu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire qlu_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output qlu_pkg::out_item_t                      out_data
);
    import qlu_pkg::*;

    state_t                state_reg;
    state_t                state_next;

    logic [RATE_W-1:0]     learning_rate_reg;
    logic [RATE_W-1:0]     discount_reg;
    logic [THRESH_W-1:0]   explore_threshold_reg;
    logic                  learn_mode_reg;

    in_item_t              item_reg;
    state_idx_t            cur_state_reg;
    action_t               cur_action_reg;
    action_t               sarsa_action_reg;
    value_t                new_value_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    mem_ctrl_t             mem_ctrl;
    upd_ctrl_t             upd_ctrl;
    logic                  eval_load;
    logic                  nv_load;
    logic                  out_load;
    logic                  out_free;
    logic                  accept;

    row_t                  next_row;
    row_t                  cur_row;
    row_t                  wr_row;
    row_t                  fwd_row;
    state_idx_t            next_state;
    action_t               random_pick;
    logic                  explore;
    action_t               eval_greedy;
    action_t               eval_pick;
    value_t                target_value;
    value_t                q_value;
    value_t                new_value;
    action_t               final_action;
    out_item_t             result;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign next_state = item_reg.state_index[STATE_W-1:0];
    assign random_pick = item_reg.random_action[ACTION_W-1:0];
    assign explore    = item_reg.explore_draw < explore_threshold_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg     <= LEARNING_RATE_RST;
            discount_reg          <= DISCOUNT_RST;
            explore_threshold_reg <= EXPLORE_THRESHOLD_RST;
            learn_mode_reg        <= MODE_QLEARN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LEARNING_RATE:     learning_rate_reg     <= cfg_data[RATE_W-1:0];
                CFG_DISCOUNT:          discount_reg          <= cfg_data[RATE_W-1:0];
                CFG_EXPLORE_THRESHOLD: explore_threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_LEARN_MODE:        learn_mode_reg        <= cfg_data[0];
                default:               learn_mode_reg        <= learn_mode_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = (item_reg.command == CMD_STEP) ? ST_SCALE : ST_OUT;
            ST_SCALE: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall           = 1'b1;
        mem_ctrl           = '0;
        upd_ctrl           = '0;
        eval_load          = 1'b0;
        nv_load            = 1'b0;
        out_load           = 1'b0;
        case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_READ:  mem_ctrl.rd_en = 1'b1;
            ST_EVAL:
            begin
                upd_ctrl.load_gv = 1'b1;
                eval_load        = 1'b1;
            end
            ST_SCALE: upd_ctrl.load_prod = 1'b1;
            ST_WRITE:
            begin
                mem_ctrl.wr_en = 1'b1;
                nv_load        = 1'b1;
            end
            ST_OUT:   out_load = out_free;
            default:  in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_state_reg  <= '0;
            cur_action_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                cur_state_reg  <= next_state;
                cur_action_reg <= final_action;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (eval_load)
        begin
            sarsa_action_reg <= eval_pick;
        end
        if (nv_load)
        begin
            new_value_reg <= new_value;
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    qlu_qmem u_qmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mem_ctrl),
        .addr_a    (next_state),
        .addr_b    (cur_state_reg),
        .wr_addr   (cur_state_reg),
        .wr_data   (wr_row),
        .rd_data_a (next_row),
        .rd_data_b (cur_row)
    );

    // evaluate: target value from the next row, current entry from own row
    assign eval_greedy  = greedy_action(next_row);
    assign eval_pick    = explore ? random_pick : eval_greedy;
    assign target_value = (learn_mode_reg == MODE_SARSA) ? $signed(next_row[eval_pick])
                                                         : $signed(next_row[eval_greedy]);
    assign q_value      = $signed(cur_row[cur_action_reg]);

    qlu_update u_update (
        .clk          (clk),
        .ctrl         (upd_ctrl),
        .target_value (target_value),
        .q_value      (q_value),
        .reward       (item_reg.reward),
        .alpha        (clamp_rate(learning_rate_reg)),
        .gamma        (clamp_rate(discount_reg)),
        .new_value    (new_value)
    );

    always_comb
    begin
        wr_row                 = cur_row;
        wr_row[cur_action_reg] = new_value;
    end

    // forward the written entry when the next state is the updated row
    always_comb
    begin
        fwd_row = next_row;
        if (item_reg.command == CMD_STEP && next_state == cur_state_reg)
        begin
            fwd_row[cur_action_reg] = new_value_reg;
        end
    end

    always_comb
    begin
        if (item_reg.command == CMD_STEP && learn_mode_reg == MODE_SARSA)
        begin
            final_action = sarsa_action_reg;
        end
        else if (explore)
        begin
            final_action = random_pick;
        end
        else
        begin
            final_action = greedy_action(fwd_row);
        end
        result.chosen_action = 2'(final_action);
        result.explored      = explore;
        result.updated_value = (item_reg.command == CMD_STEP) ? 16'(new_value_reg) : '0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
